>>> rtl/vtgd_pkg.sv
// Package for the vector tile geometry decoder: grammar phase codes,
// command ids, status and vertex kind codes, and the word structs.
// No dependencies.
package vtgd_pkg;

  // Grammar phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_MOVE_CMD  = 4'd1;
  localparam logic [3:0] PH_MOVE_X    = 4'd2;
  localparam logic [3:0] PH_MOVE_Y    = 4'd3;
  localparam logic [3:0] PH_LINE_CMD  = 4'd4;
  localparam logic [3:0] PH_LINE_X    = 4'd5;
  localparam logic [3:0] PH_LINE_Y    = 4'd6;
  localparam logic [3:0] PH_CLOSE_CMD = 4'd7;
  localparam logic [3:0] PH_DONE      = 4'd8;
  localparam logic [3:0] PH_DRAIN     = 4'd9;

  // Command ids
  localparam logic [2:0] CMD_MOVE  = 3'd1;
  localparam logic [2:0] CMD_LINE  = 3'd2;
  localparam logic [2:0] CMD_CLOSE = 3'd7;

  // Geometry types
  localparam logic [1:0] GK_UNKNOWN = 2'd0;
  localparam logic [1:0] GK_POINT   = 2'd1;
  localparam logic [1:0] GK_LINE    = 2'd2;
  localparam logic [1:0] GK_POLYGON = 2'd3;

  // Vertex kinds
  localparam logic [1:0] VK_POINT = 2'd0;
  localparam logic [1:0] VK_FIRST = 2'd1;
  localparam logic [1:0] VK_MORE  = 2'd2;
  localparam logic [1:0] VK_CLOSE = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNEXP_CMD = 3'd1;
  localparam logic [2:0] ST_BAD_COUNT = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_TRAILING  = 3'd4;

  // One input word
  typedef struct packed {
    logic [31:0] geometry_word;
    logic [1:0]  geom_kind;
    logic        feature_start;
    logic        feature_end;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [1:0]         vertex_kind;
    logic               part_done;
    logic               last_of_feature;
    logic [2:0]         status;
  } result_t;

endpackage

>>> rtl/vtgd_in_stage.sv
// Input register stage of the geometry decoder: captures one word from the
// slave stream and holds it until the decode engine takes it.
// Depends on vtgd_pkg.
module vtgd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  vtgd_pkg::in_item_t s_item,
  input  logic               advance,
  output logic               item_valid,
  output vtgd_pkg::in_item_t item
);

  // Take a new word when empty or when the held word moves on this cycle
  assign s_tready = !item_valid || advance;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

>>> rtl/vtgd_engine.sv
// Decode engine of the geometry decoder: grammar phase, cursor and ring
// start registers, with the single-pass command/parameter step logic.
// Depends on vtgd_pkg.
module vtgd_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  vtgd_pkg::in_item_t item,
  output logic               emit,
  output vtgd_pkg::result_t  res
);

  logic [3:0]  phase, phase_next;
  logic [1:0]  kind_held, kind_held_next;
  logic [28:0] words_left, words_left_next;
  logic [31:0] cursor_x, cursor_x_next;
  logic [31:0] cursor_y, cursor_y_next;
  logic [31:0] delta_x_held, delta_x_held_next;
  logic [31:0] ring_start_x, ring_start_x_next;
  logic [31:0] ring_start_y, ring_start_y_next;

  // Step one word through the grammar
  always_comb begin
    logic [2:0]  id;
    logic [28:0] cnt;
    logic [31:0] delta;
    logic        err;
    logic [31:0] ox, oy;
    logic [1:0]  vk;
    logic        pd;
    logic [2:0]  st;
    logic        em;

    id    = item.geometry_word[2:0];
    cnt   = item.geometry_word[31:3];
    delta = {1'b0, item.geometry_word[31:1]} ^ {32{item.geometry_word[0]}};
    err   = 1'b0;
    ox    = '0;
    oy    = '0;
    vk    = vtgd_pkg::VK_POINT;
    pd    = 1'b0;
    st    = vtgd_pkg::ST_OK;
    em    = 1'b0;

    phase_next        = phase;
    kind_held_next    = kind_held;
    words_left_next   = words_left;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    delta_x_held_next = delta_x_held;
    ring_start_x_next = ring_start_x;
    ring_start_y_next = ring_start_y;

    // Restart the grammar and cursor on a feature start
    if (item.feature_start) begin
      cursor_x_next     = '0;
      cursor_y_next     = '0;
      delta_x_held_next = '0;
      ring_start_x_next = '0;
      ring_start_y_next = '0;
      words_left_next   = '0;
      kind_held_next    = item.geom_kind;
      phase_next = (item.geom_kind == vtgd_pkg::GK_UNKNOWN) ? vtgd_pkg::PH_DRAIN
                                                             : vtgd_pkg::PH_MOVE_CMD;
    end

    if (phase_next != vtgd_pkg::PH_IDLE) begin
      case (phase_next)
        vtgd_pkg::PH_MOVE_CMD: begin
          if (id != vtgd_pkg::CMD_MOVE) begin
            st  = vtgd_pkg::ST_UNEXP_CMD;
            err = 1'b1;
          end else if (cnt == '0 ||
                       (kind_held_next != vtgd_pkg::GK_POINT && cnt != 29'd1)) begin
            st  = vtgd_pkg::ST_BAD_COUNT;
            err = 1'b1;
          end else begin
            words_left_next = cnt;
            phase_next      = vtgd_pkg::PH_MOVE_X;
          end
        end
        vtgd_pkg::PH_MOVE_X: begin
          delta_x_held_next = delta;
          phase_next        = vtgd_pkg::PH_MOVE_Y;
        end
        vtgd_pkg::PH_LINE_X: begin
          delta_x_held_next = delta;
          phase_next        = vtgd_pkg::PH_LINE_Y;
        end
        vtgd_pkg::PH_MOVE_Y: begin
          cursor_x_next = cursor_x_next + delta_x_held_next;
          cursor_y_next = cursor_y_next + delta;
          em = 1'b1;
          ox = cursor_x_next;
          oy = cursor_y_next;
          if (kind_held_next == vtgd_pkg::GK_POINT) begin
            vk              = vtgd_pkg::VK_POINT;
            words_left_next = words_left_next - 29'd1;
            phase_next = (words_left_next != '0) ? vtgd_pkg::PH_MOVE_X
                                                 : vtgd_pkg::PH_DONE;
          end else begin
            vk                = vtgd_pkg::VK_FIRST;
            ring_start_x_next = cursor_x_next;
            ring_start_y_next = cursor_y_next;
            phase_next        = vtgd_pkg::PH_LINE_CMD;
          end
        end
        vtgd_pkg::PH_LINE_CMD: begin
          if (id != vtgd_pkg::CMD_LINE) begin
            st  = vtgd_pkg::ST_UNEXP_CMD;
            err = 1'b1;
          end else if (cnt == '0) begin
            st  = vtgd_pkg::ST_BAD_COUNT;
            err = 1'b1;
          end else begin
            words_left_next = cnt;
            phase_next      = vtgd_pkg::PH_LINE_X;
          end
        end
        vtgd_pkg::PH_LINE_Y: begin
          cursor_x_next   = cursor_x_next + delta_x_held_next;
          cursor_y_next   = cursor_y_next + delta;
          em              = 1'b1;
          ox              = cursor_x_next;
          oy              = cursor_y_next;
          vk              = vtgd_pkg::VK_MORE;
          words_left_next = words_left_next - 29'd1;
          if (words_left_next != '0) begin
            phase_next = vtgd_pkg::PH_LINE_X;
          end else if (kind_held_next == vtgd_pkg::GK_LINE) begin
            pd         = 1'b1;
            phase_next = vtgd_pkg::PH_MOVE_CMD;
          end else begin
            phase_next = vtgd_pkg::PH_CLOSE_CMD;
          end
        end
        vtgd_pkg::PH_CLOSE_CMD: begin
          if (id != vtgd_pkg::CMD_CLOSE) begin
            st  = vtgd_pkg::ST_UNEXP_CMD;
            err = 1'b1;
          end else if (cnt != 29'd1) begin
            st  = vtgd_pkg::ST_BAD_COUNT;
            err = 1'b1;
          end else begin
            em         = 1'b1;
            ox         = ring_start_x_next;
            oy         = ring_start_y_next;
            vk         = vtgd_pkg::VK_CLOSE;
            pd         = 1'b1;
            phase_next = vtgd_pkg::PH_MOVE_CMD;
          end
        end
        vtgd_pkg::PH_DONE: begin
          st  = vtgd_pkg::ST_TRAILING;
          err = 1'b1;
        end
        default: begin
        end
      endcase

      // Report the error with cleared vertex fields, then swallow the rest
      if (err) begin
        em         = 1'b1;
        ox         = '0;
        oy         = '0;
        vk         = vtgd_pkg::VK_POINT;
        pd         = 1'b0;
        phase_next = vtgd_pkg::PH_DRAIN;
      end

      // Close the feature; flag an unfinished part as truncated
      if (item.feature_end) begin
        if (phase_next != vtgd_pkg::PH_MOVE_CMD && phase_next != vtgd_pkg::PH_DONE &&
            phase_next != vtgd_pkg::PH_DRAIN) begin
          if (!em) begin
            ox = '0;
            oy = '0;
            vk = vtgd_pkg::VK_POINT;
            pd = 1'b0;
          end
          em = 1'b1;
          st = vtgd_pkg::ST_TRUNCATED;
        end
        phase_next = vtgd_pkg::PH_IDLE;
      end
    end

    emit                = em;
    res.coord_x         = ox;
    res.coord_y         = oy;
    res.vertex_kind     = vk;
    res.part_done       = pd;
    res.last_of_feature = item.feature_end;
    res.status          = st;
  end

  // Advance the grammar state on each processed word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= vtgd_pkg::PH_IDLE;
      kind_held    <= '0;
      words_left   <= '0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      delta_x_held <= '0;
      ring_start_x <= '0;
      ring_start_y <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      kind_held    <= kind_held_next;
      words_left   <= words_left_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      delta_x_held <= delta_x_held_next;
      ring_start_x <= ring_start_x_next;
      ring_start_y <= ring_start_y_next;
    end
  end

endmodule

>>> rtl/vector_tile_geometry_decoder_core.sv
// Vector tile geometry decoder, top level. Takes one geometry word per
// cycle while results are taken and returns at most one vertex or status
// word per input word. Depends on vtgd_pkg, vtgd_in_stage and vtgd_engine.
//
// The decoder accepts one geometry word every clock cycle while the output
// side takes results. An accepted word waits in the input register; its
// result is registered in the output register and valid on the master
// stream from there. Each word passes once through the engine between
// the input register and the output register: a command decode, one 32-bit
// cursor add per axis and the phase update, so the rate is one word per
// cycle while results are taken. Words that produce no result (commands, x
// deltas, swallowed words) still take an engine step. Set feature_start on
// the first word of every feature; words outside a feature are dropped,
// and a nonzero status marks a grammar error, truncation or trailing words.
module vector_tile_geometry_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // geometry_word
  input  logic [2:0]  s_tuser,   // geom_kind[1:0], feature_start[2]
  input  logic        s_tlast,   // feature_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // coord_x[31:0], coord_y[63:32]
  output logic [5:0]  m_tuser,   // vertex_kind[1:0], part_done[2], status[5:3]
  output logic        m_tlast    // last_of_feature
);

  vtgd_pkg::in_item_t s_item;
  vtgd_pkg::in_item_t item;
  vtgd_pkg::result_t  res_new;
  vtgd_pkg::result_t  res;
  logic               item_valid;
  logic               out_valid;
  logic               out_free;
  logic               fire;
  logic               emit;

  assign s_item.geometry_word = s_tdata;
  assign s_item.geom_kind     = s_tuser[1:0];
  assign s_item.feature_start = s_tuser[2];
  assign s_item.feature_end   = s_tlast;

  // Process the held word when the output register can take its result
  assign out_free = !out_valid || m_tready;
  assign fire     = item_valid && out_free;

  vtgd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  vtgd_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .emit (emit),
    .res  (res_new)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res <= res_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {res.coord_y, res.coord_x};
  assign m_tuser  = {res.status, res.part_done, res.vertex_kind};
  assign m_tlast  = res.last_of_feature;

  // Grammar errors carry cleared vertex fields
  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.status == vtgd_pkg::ST_UNEXP_CMD ||
                  res.status == vtgd_pkg::ST_BAD_COUNT ||
                  res.status == vtgd_pkg::ST_TRAILING)
    |-> (res.coord_x == '0 && res.coord_y == '0 &&
         res.vertex_kind == vtgd_pkg::VK_POINT && !res.part_done))
    else $error("error result with nonzero vertex fields");

  // A closing vertex always ends its ring
  a_close_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.vertex_kind == vtgd_pkg::VK_CLOSE |-> res.part_done)
    else $error("closing vertex without part_done");

  // A full input stage behind a stalled output refuses new words
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    item_valid && out_valid && !m_tready |-> !s_tready)
    else $error("input accepted while both stages are stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

>>> test/vector_tile_geometry_decoder_core_test.sv
// Testbench for vector_tile_geometry_decoder_core: a self-checking stream test
// that predicts each vertex or status word and compares it field by field.
// Depends on vtgd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module vector_tile_geometry_decoder_core_test;
  import vtgd_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_WORDS = 920;
  localparam int PRINT_CAP    = 100;
  localparam int DRAIN_CYCLES = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // geometry_word
  logic [2:0]  s_tuser = '0;   // geom_kind[1:0], feature_start[2]
  logic        s_tlast = 1'b0; // feature_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // coord_x[31:0], coord_y[63:32]
  logic [5:0]  m_tuser;        // vertex_kind[1:0], part_done[2], status[5:3]
  logic        m_tlast;        // last_of_feature

  vector_tile_geometry_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Expected vertex and status words, oldest first
  result_t     vertex_q[$];
  // Words of the feature being built, and where its commands sit
  logic [31:0] geom_words_q[$];
  int          cmd_pos[$];

  int err_count   = 0;
  int cycle_count = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int rx_hold_req = 0;

  // Decoder shadow state
  logic [3:0]  g_phase = PH_IDLE;
  logic [1:0]  g_kind  = GK_UNKNOWN;
  logic [28:0] g_left  = '0;
  logic [31:0] cur_x   = '0;
  logic [31:0] cur_y   = '0;
  logic [31:0] held_dx = '0;
  logic [31:0] ring_x  = '0;
  logic [31:0] ring_y  = '0;
  bit          g_err   = 1'b0;

  initial forever #(CLK_HALF) clk = ~clk;

  task automatic report_error(input string what);
    if (err_count < PRINT_CAP)
      $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic logic [31:0] zigzag_decode(input logic [31:0] w);
    return (w >> 1) ^ {32{w[0]}};
  endfunction

  function automatic logic [31:0] zigzag_encode(input logic [31:0] d);
    return (d << 1) ^ {32{d[31]}};
  endfunction

  // Advance the shadow grammar by one word and queue the word it yields
  function automatic void predict_vertex(input logic [31:0] w, input logic [1:0] kind,
                                         input logic fs, input logic fe);
    logic [2:0]  id;
    logic [28:0] cnt;
    bit          emit;
    bit          err;
    result_t     r;
    id   = w[2:0];
    cnt  = w[31:3];
    emit = 1'b0;
    err  = 1'b0;
    r    = '0;
    if (fs) begin
      cur_x   = '0;
      cur_y   = '0;
      held_dx = '0;
      ring_x  = '0;
      ring_y  = '0;
      g_left  = '0;
      g_err   = 1'b0;
      g_kind  = kind;
      g_phase = (kind == GK_UNKNOWN) ? PH_DRAIN : PH_MOVE_CMD;
    end
    if (g_phase == PH_IDLE) return;

    case (g_phase)
      PH_MOVE_CMD: begin
        if (id != CMD_MOVE) begin
          r.status = ST_UNEXP_CMD;
          err = 1'b1;
        end else if (cnt == 0 || (g_kind != GK_POINT && cnt != 1)) begin
          r.status = ST_BAD_COUNT;
          err = 1'b1;
        end else begin
          g_left  = cnt;
          g_phase = PH_MOVE_X;
        end
      end
      PH_MOVE_X, PH_LINE_X: begin
        held_dx = zigzag_decode(w);
        g_phase = g_phase + 4'd1;
      end
      PH_MOVE_Y: begin
        cur_x = cur_x + held_dx;
        cur_y = cur_y + zigzag_decode(w);
        emit = 1'b1;
        r.coord_x = cur_x;
        r.coord_y = cur_y;
        if (g_kind == GK_POINT) begin
          r.vertex_kind = VK_POINT;
          g_left  = g_left - 29'd1;
          g_phase = (g_left != 0) ? PH_MOVE_X : PH_DONE;
        end else begin
          r.vertex_kind = VK_FIRST;
          ring_x  = cur_x;
          ring_y  = cur_y;
          g_phase = PH_LINE_CMD;
        end
      end
      PH_LINE_CMD: begin
        if (id != CMD_LINE) begin
          r.status = ST_UNEXP_CMD;
          err = 1'b1;
        end else if (cnt == 0) begin
          r.status = ST_BAD_COUNT;
          err = 1'b1;
        end else begin
          g_left  = cnt;
          g_phase = PH_LINE_X;
        end
      end
      PH_LINE_Y: begin
        cur_x = cur_x + held_dx;
        cur_y = cur_y + zigzag_decode(w);
        emit = 1'b1;
        r.coord_x = cur_x;
        r.coord_y = cur_y;
        r.vertex_kind = VK_MORE;
        g_left = g_left - 29'd1;
        if (g_left != 0) begin
          g_phase = PH_LINE_X;
        end else if (g_kind == GK_LINE) begin
          r.part_done = 1'b1;
          g_phase = PH_MOVE_CMD;
        end else begin
          g_phase = PH_CLOSE_CMD;
        end
      end
      PH_CLOSE_CMD: begin
        if (id != CMD_CLOSE) begin
          r.status = ST_UNEXP_CMD;
          err = 1'b1;
        end else if (cnt != 1) begin
          r.status = ST_BAD_COUNT;
          err = 1'b1;
        end else begin
          emit = 1'b1;
          r.coord_x = ring_x;
          r.coord_y = ring_y;
          r.vertex_kind = VK_CLOSE;
          r.part_done = 1'b1;
          g_phase = PH_MOVE_CMD;
        end
      end
      PH_DONE: begin
        r.status = ST_TRAILING;
        err = 1'b1;
      end
      default: ;
    endcase

    // Grammar error: blank the vertex and swallow the rest of the feature
    if (err) begin
      emit = 1'b1;
      r.coord_x = '0;
      r.coord_y = '0;
      r.vertex_kind = VK_POINT;
      r.part_done = 1'b0;
      g_err = 1'b1;
      g_phase = PH_DRAIN;
    end

    // Feature end inside an unfinished part is a truncation
    if (fe) begin
      if (g_phase != PH_MOVE_CMD && g_phase != PH_DONE && g_phase != PH_DRAIN) begin
        if (!emit) begin
          r.coord_x = '0;
          r.coord_y = '0;
          r.vertex_kind = VK_POINT;
          r.part_done = 1'b0;
        end
        emit = 1'b1;
        r.status = ST_TRUNCATED;
        g_err = 1'b1;
      end
      g_phase = PH_IDLE;
    end

    if (emit) begin
      r.last_of_feature = fe;
      vertex_q.push_back(r);
    end
  endfunction

  // Offer one word after a random gap, hold it until taken, then predict
  task automatic send_word(input logic [31:0] w, input logic [1:0] kind,
                           input logic fs, input logic fe);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tuser  <= {fs, kind};
    s_tlast  <= fe;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertex(w, kind, fs, fe);
  endtask

  // Send the built feature; the type rides only on its first word
  task automatic send_feature(input logic [1:0] kind, input bit with_end);
    int n;
    n = geom_words_q.size();
    for (int i = 0; i < n; i++)
      send_word(geom_words_q[i], (i == 0) ? kind : 2'($urandom_range(0, 3)),
                i == 0, with_end && i == n - 1);
  endtask

  function automatic logic [31:0] pick_delta();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 400)) - 32'd200;
  endfunction

  function automatic void add_cmd(input logic [2:0] id, input logic [28:0] cnt);
    cmd_pos.push_back(geom_words_q.size());
    geom_words_q.push_back({cnt, id});
  endfunction

  function automatic void add_pair();
    geom_words_q.push_back(zigzag_encode(pick_delta()));
    geom_words_q.push_back(zigzag_encode(pick_delta()));
  endfunction

  function automatic void clear_feature();
    geom_words_q.delete();
    cmd_pos.delete();
  endfunction

  // Build a well-formed feature of the given type with small random sizes
  function automatic void build_feature(input logic [1:0] kind);
    int parts;
    int len;
    clear_feature();
    if (kind == GK_POINT) begin
      len = $urandom_range(1, 6);
      add_cmd(CMD_MOVE, 29'(len));
      repeat (len) add_pair();
    end else begin
      parts = (kind == GK_LINE) ? $urandom_range(1, 3) : $urandom_range(1, 2);
      repeat (parts) begin
        add_cmd(CMD_MOVE, 29'd1);
        add_pair();
        len = $urandom_range(1, 5);
        add_cmd(CMD_LINE, 29'(len));
        repeat (len) add_pair();
        if (kind == GK_POLYGON) add_cmd(CMD_CLOSE, 29'd1);
      end
    end
  endfunction

  // Break a feature: cut it short, garble a word, add a tail, or spoil a count
  function automatic void corrupt_feature();
    int          n;
    int          idx;
    logic [31:0] w;
    n = geom_words_q.size();
    case ($urandom_range(0, 3))
      0: if (n > 1) begin
        idx = $urandom_range(1, n - 1);
        while (geom_words_q.size() > idx) void'(geom_words_q.pop_back());
      end
      1: geom_words_q[$urandom_range(0, n - 1)] = $urandom;
      2: geom_words_q.push_back($urandom);
      default: begin
        idx = cmd_pos[$urandom_range(0, cmd_pos.size() - 1)];
        w = geom_words_q[idx];
        case ($urandom_range(0, 2))
          0: w[31:3] = '0;
          1: w[31:3] = 29'd2;
          default: w[31:3] = 29'($urandom);
        endcase
        geom_words_q[idx] = w;
      end
    endcase
  endfunction

  // Points with extreme deltas, then a trailing word
  task automatic test_point_feature();
    clear_feature();
    add_cmd(CMD_MOVE, 29'd2);
    geom_words_q.push_back(32'hFFFF_FFFF);
    geom_words_q.push_back(32'hFFFF_FFFE);
    geom_words_q.push_back(32'h0000_0000);
    geom_words_q.push_back(32'hFFFF_FFFF);
    geom_words_q.push_back(32'hFFFF_FFFF);
    send_feature(GK_POINT, 1'b1);
  endtask

  task automatic test_line_feature();
    clear_feature();
    add_cmd(CMD_MOVE, 29'd1);
    add_pair();
    add_cmd(CMD_LINE, 29'd1);
    add_pair();
    send_feature(GK_LINE, 1'b1);
  endtask

  task automatic test_polygon_feature();
    clear_feature();
    add_cmd(CMD_MOVE, 29'd1);
    add_pair();
    add_cmd(CMD_LINE, 29'd2);
    add_pair();
    add_pair();
    add_cmd(CMD_CLOSE, 29'd1);
    send_feature(GK_POLYGON, 1'b1);
  endtask

  // Wrong command first, its final word swallowed; then a zero move count
  task automatic test_grammar_errors();
    clear_feature();
    add_cmd(CMD_LINE, 29'd1);
    geom_words_q.push_back(32'h0000_0000);
    send_feature(GK_LINE, 1'b1);
    clear_feature();
    add_cmd(CMD_MOVE, 29'd0);
    send_feature(GK_POINT, 1'b1);
  endtask

  // Abandon an open line, end the next one on its first vertex, cut a huge point run
  task automatic test_truncation();
    clear_feature();
    add_cmd(CMD_MOVE, 29'd1);
    geom_words_q.push_back(zigzag_encode(pick_delta()));
    send_feature(GK_LINE, 1'b0);
    clear_feature();
    add_cmd(CMD_MOVE, 29'd1);
    add_pair();
    send_feature(GK_LINE, 1'b1);
    clear_feature();
    add_cmd(CMD_MOVE, 29'h1FFF_FFFF);
    send_feature(GK_POINT, 1'b1);
  endtask

  // Stray word with no feature open, then a feature of unknown type
  task automatic test_skipped_words();
    send_word(32'hFFFF_FFFF, GK_POLYGON, 1'b0, 1'b1);
    clear_feature();
    add_cmd(CMD_MOVE, 29'd1);
    send_feature(GK_UNKNOWN, 1'b1);
  endtask

  // Stall the output for a long stretch while a long point run streams in
  task automatic test_backpressure();
    bit idle_save;
    idle_save = tx_idle_on;
    tx_idle_on = 1'b0;
    rx_hold_req = 300;
    clear_feature();
    add_cmd(CMD_MOVE, 29'd40);
    repeat (40) add_pair();
    send_feature(GK_POINT, 1'b1);
    tx_idle_on = idle_save;
  endtask

  // Mostly well-formed features with random content, some broken, some noise
  task automatic test_random_features();
    int         words_sent;
    int         pick;
    logic [1:0] kind;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 5) == 0) tx_idle_on = !tx_idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        repeat ($urandom_range(1, 3))
          send_word($urandom, 2'($urandom_range(0, 3)), 1'b0, 1'($urandom_range(0, 1)));
      end else if (pick < 10) begin
        clear_feature();
        repeat ($urandom_range(1, 4)) geom_words_q.push_back($urandom);
        send_feature(GK_UNKNOWN, 1'b1);
        words_sent += geom_words_q.size();
      end else begin
        kind = 2'($urandom_range(1, 3));
        build_feature(kind);
        if (pick >= 72) corrupt_feature();
        send_feature(kind, pick < 96);
        words_sent += geom_words_q.size();
      end
    end
  endtask

  // Output side: random stalls per word, long hold-off on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (rx_hold_req > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end
      if ($urandom_range(0, 40) == 0) rx_idle_on = !rx_idle_on;
      stall = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        report_error($sformatf("unexpected word tdata=0x%0h tuser=0x%0h", m_tdata, m_tuser));
      end else begin
        want = vertex_q.pop_front();
        check_field("coord_x", m_tdata[31:0], want.coord_x);
        check_field("coord_y", m_tdata[63:32], want.coord_y);
        check_field("vertex_kind", 32'(m_tuser[1:0]), 32'(want.vertex_kind));
        check_field("part_done", 32'(m_tuser[2]), 32'(want.part_done));
        check_field("last_of_feature", 32'(m_tlast), 32'(want.last_of_feature));
        check_field("status", 32'(m_tuser[5:3]), 32'(want.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL vector_tile_geometry_decoder_core");
      $finish;
    end
  end

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_point_feature();
    test_line_feature();
    test_polygon_feature();
    test_grammar_errors();
    test_truncation();
    test_skipped_words();
    test_backpressure();
    test_random_features();

    // Drain the outstanding words, then allow for the pipeline
    s_tvalid <= 1'b0;
    waited = 0;
    while (vertex_q.size() > 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (vertex_q.size() > 0)
      report_error($sformatf("%0d expected words never arrived", vertex_q.size()));

    if (err_count == 0) begin
      $display("PASS vector_tile_geometry_decoder_core");
    end else begin
      $display("FAIL vector_tile_geometry_decoder_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/vtgd_pkg.sv
rtl/vtgd_in_stage.sv
rtl/vtgd_engine.sv
rtl/vector_tile_geometry_decoder_core.sv
test/vector_tile_geometry_decoder_core_test.sv
